/* hw/rtl/b64e_pkg.sv */
// Package for the Base64 stream encoder: constants, group record and alphabet lookup.
`timescale 1ns / 1ps
`default_nettype none
package b64e_pkg;

	localparam int unsigned GROUPS_PER_LINE_DEF = 19;
	localparam int unsigned LINE_W = 5;
	localparam int unsigned IDX_W = 3;

	localparam logic [7:0] PAD_CHAR = 8'd61;
	localparam logic [7:0] LINE_FEED = 8'd10;

	// Serializer positions within one group
	localparam logic [IDX_W-1:0] IDX_FIRST = 3'd0;
	localparam logic [IDX_W-1:0] IDX_LAST_CHAR = 3'd3;
	localparam logic [IDX_W-1:0] IDX_LINE_FEED = 3'd4;

	// One encoded group: four characters, optional line feed, end-of-message flag
	typedef struct packed {
		logic [3:0][7:0] chars;
		logic            lf;
		logic            last;
	} b64e_group_t;

	// Map one sextet onto the standard alphabet
	function automatic logic [7:0] sextet_char(input logic [5:0] sx);
		logic [7:0] v;
		v = {2'b00, sx};
		if (sx < 6'd26) begin
			sextet_char = v + 8'd65;
		end else if (sx < 6'd52) begin
			sextet_char = v + 8'd71;
		end else if (sx < 6'd62) begin
			sextet_char = v - 8'd4;
		end else if (sx == 6'd62) begin
			sextet_char = 8'd43;
		end else begin
			sextet_char = 8'd47;
		end
	endfunction

endpackage
`default_nettype wire

/* hw/rtl/b64e_if.sv */
// Valid/ready channel interfaces for the byte input and the character output.
`timescale 1ns / 1ps
`default_nettype none
interface b64e_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       final_byte;

	modport source (output valid, output data_byte, output final_byte, input ready);
	modport sink (input valid, input data_byte, input final_byte, output ready);
endinterface

interface b64e_char_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_char;
	logic       run_end;
	logic       message_end;

	modport source (output valid, output out_char, output run_end, output message_end,
		input ready);
	modport sink (input valid, input out_char, input run_end, input message_end,
		output ready);
endinterface
`default_nettype wire

/* hw/rtl/base64_stream_encoder.sv */
// Top level of the Base64 stream encoder: byte collector plus character serializer.
//
// Usage:
//   bytes: one message byte per beat, final_byte marks the last byte of a message.
//   chars: one ASCII character per beat: alphabet, '=' padding or a line feed after
//          every GROUPS_PER_LINE-th group. run_end flags the last character caused
//          by an input byte, message_end the last character of the message.
// Path: a byte that closes a group is held in the group register when it is
//   taken; its first character then reaches chars through the output register.
// Throughput: bytes that do not close a group are taken every cycle. A closing
//   byte waits until the previous group has started its last character, since the
//   serializer sends one character per cycle while chars.ready does not stall it.
// Reset: clears the pending count, the line counter and all valid flags; the
//   next byte starts a fresh message.
// Stall: the output register holds its character while chars.ready is low; the
//   held group then stays put and only non-closing bytes keep being taken.
`timescale 1ns / 1ps
`default_nettype none
module base64_stream_encoder #(
	parameter int unsigned GROUPS_PER_LINE = b64e_pkg::GROUPS_PER_LINE_DEF
) (
	input wire            clk,
	input wire            arst_n,
	b64e_byte_if.sink     bytes,
	b64e_char_if.source   chars
);
	import b64e_pkg::*;

	b64e_group_t      grp;
	logic             grp_valid;
	logic             grp_take;
	logic             load;
	logic             is_last;
	logic [7:0]       char_d;
	logic [IDX_W-1:0] idx_q;
	logic             out_valid_q;
	logic [7:0]       out_char_q;
	logic             run_end_q;
	logic             message_end_q;

	b64e_pack #(
		.GROUPS_PER_LINE(GROUPS_PER_LINE)
	) u_pack (
		.clk       (clk),
		.arst_n    (arst_n),
		.bytes     (bytes),
		.grp       (grp),
		.grp_valid (grp_valid),
		.grp_take  (grp_take)
	);

	// Pick the next character of the held group
	assign load = grp_valid && (!out_valid_q || chars.ready);
	assign is_last = (idx_q == (grp.lf ? IDX_LINE_FEED : IDX_LAST_CHAR));
	assign grp_take = load && is_last;

	always_comb begin
		if (idx_q == IDX_LINE_FEED) begin
			char_d = LINE_FEED;
		end else begin
			char_d = grp.chars[IDX_LAST_CHAR[1:0] - idx_q[1:0]];
		end
	end

	// Advance the serializer and the output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= IDX_FIRST;
			out_valid_q <= 1'b0;
		end else begin
			if (load) begin
				idx_q <= is_last ? IDX_FIRST : idx_q + IDX_W'(1);
				out_valid_q <= 1'b1;
			end else if (chars.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Hold the output payload
	always_ff @(posedge clk) begin
		if (load) begin
			out_char_q <= char_d;
			run_end_q <= is_last;
			message_end_q <= is_last && grp.last;
		end
	end

	assign chars.valid = out_valid_q;
	assign chars.out_char = out_char_q;
	assign chars.run_end = run_end_q;
	assign chars.message_end = message_end_q;

	a_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		idx_q <= IDX_LINE_FEED) else $error("serializer index out of range");
	a_idx_group: assert property (@(posedge clk) disable iff (!arst_n)
		idx_q != IDX_FIRST |-> grp_valid) else $error("serializer mid-group without group");
	a_end_order: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && message_end_q |-> run_end_q) else $error("message end without run end");

endmodule
`default_nettype wire

/* hw/rtl/b64e_pack.sv */
// Byte collector: gathers bytes into 24-bit groups, maps sextets and tracks line length.
`timescale 1ns / 1ps
`default_nettype none
module b64e_pack #(
	parameter int unsigned GROUPS_PER_LINE = b64e_pkg::GROUPS_PER_LINE_DEF
) (
	input  wire                  clk,
	input  wire                  arst_n,
	b64e_byte_if.sink            bytes,
	output b64e_pkg::b64e_group_t grp,
	output logic                 grp_valid,
	input  wire                  grp_take
);
	import b64e_pkg::*;

	logic [7:0]        pend0_q;
	logic [7:0]        pend1_q;
	logic [1:0]        cnt_q;
	logic [LINE_W-1:0] line_q;
	logic              grp_valid_q;
	b64e_group_t       grp_s1;

	logic              completes;
	logic              accept;
	logic [1:0]        have;
	logic [23:0]       bits24;
	logic [LINE_W-1:0] line_nxt;
	logic              line_full;
	b64e_group_t       grp_d;

	// Decide whether this beat closes a group
	assign completes = (cnt_q == 2'd2) || bytes.final_byte;
	assign bytes.ready = !completes || !grp_valid_q || grp_take;
	assign accept = bytes.valid && bytes.ready;
	assign have = cnt_q + 2'd1;

	// Build the zero-filled group and its characters
	always_comb begin
		case (cnt_q)
			2'd0: bits24 = {bytes.data_byte, 16'h0000};
			2'd1: bits24 = {pend0_q, bytes.data_byte, 8'h00};
			default: bits24 = {pend0_q, pend1_q, bytes.data_byte};
		endcase
		for (int i = 0; i < 4; i++) begin
			if (2'(i) <= have || i == 0) begin
				grp_d.chars[3-i] = sextet_char(bits24[23-6*i -: 6]);
			end else begin
				grp_d.chars[3-i] = PAD_CHAR;
			end
		end
		line_nxt = line_q + LINE_W'(1);
		line_full = (line_nxt == '0) || (line_nxt >= LINE_W'(GROUPS_PER_LINE));
		grp_d.lf = line_full;
		grp_d.last = bytes.final_byte;
	end

	// Advance the collector state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
			line_q <= '0;
			grp_valid_q <= 1'b0;
		end else begin
			if (grp_take) begin
				grp_valid_q <= 1'b0;
			end
			if (accept) begin
				if (completes) begin
					cnt_q <= 2'd0;
					line_q <= (line_full || bytes.final_byte) ? '0 : line_nxt;
					grp_valid_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q + 2'd1;
				end
			end
		end
	end

	// Hold pending bytes and the finished group
	always_ff @(posedge clk) begin
		if (accept && !completes) begin
			if (cnt_q == 2'd0) begin
				pend0_q <= bytes.data_byte;
			end else begin
				pend1_q <= bytes.data_byte;
			end
		end
		if (accept && completes) begin
			grp_s1 <= grp_d;
		end
	end

	assign grp = grp_s1;
	assign grp_valid = grp_valid_q;

	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= 2'd2) else $error("pending count out of range");
	a_line_range: assert property (@(posedge clk) disable iff (!arst_n)
		line_q < LINE_W'(GROUPS_PER_LINE)) else $error("line counter past limit");
	a_group_loaded: assert property (@(posedge clk) disable iff (!arst_n)
		accept && completes |=> grp_valid_q) else $error("closed group not held");

endmodule
`default_nettype wire

/* tb/tb_base64_stream_encoder.sv */
// Self-checking testbench for the Base64 stream encoder: directed table, random messages.
`timescale 1ns / 1ps
module tb_base64_stream_encoder;
	import b64e_pkg::*;

	localparam int unsigned LINE_GROUPS = GROUPS_PER_LINE_DEF;
	localparam int STUCK_LIMIT = 1000;
	localparam int RANDOM_BYTES = 300;
	localparam string B64_ALPHABET =
		"ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

	// One character beat as it should appear on the output channel
	typedef struct packed {
		logic [7:0] ch;
		logic       run_end;
		logic       message_end;
	} char_beat_t;

	// Directed row: a byte, its end flag, and four literal characters or zero to predict
	typedef struct packed {
		logic [7:0]  data;
		logic        last;
		logic [31:0] literal;
	} byte_row_t;

	localparam int NUM_ROWS = 22;
	localparam byte_row_t BYTE_ROWS [NUM_ROWS] = '{
		'{8'h00, 1'b1, "AA=="},
		'{8'hFF, 1'b1, "/w=="},
		'{8'hFF, 1'b0, 32'd0}, '{8'hFF, 1'b0, 32'd0}, '{8'hFF, 1'b1, "////"},
		'{8'h00, 1'b0, 32'd0}, '{8'h00, 1'b1, "AAA="},
		'{8'h4D, 1'b0, 32'd0}, '{8'h61, 1'b0, 32'd0}, '{8'h6E, 1'b0, "TWFu"},
		'{8'h4D, 1'b0, 32'd0}, '{8'h61, 1'b1, "TWE="},
		'{8'h00, 1'b0, 32'd0}, '{8'h10, 1'b0, 32'd0}, '{8'h83, 1'b0, "ABCD"},
		'{8'hFB, 1'b1, 32'd0},
		'{8'hFB, 1'b0, 32'd0}, '{8'hEF, 1'b0, 32'd0}, '{8'hBE, 1'b1, "++++"},
		'{8'h80, 1'b0, 32'd0}, '{8'h01, 1'b1, 32'd0},
		'{8'h7F, 1'b1, 32'd0}
	};

	logic clk;
	logic arst_n;
	logic [31:0] literal_chars;

	b64e_byte_if byte_ch ();
	b64e_char_if char_ch ();

	base64_stream_encoder dut (
		.clk    (clk),
		.arst_n (arst_n),
		.bytes  (byte_ch),
		.chars  (char_ch)
	);

	// Encoder state mirror
	logic [7:0] held_bytes [2];
	logic [1:0] held_count;
	logic [4:0] groups_since_lf;

	char_beat_t expected_chars [$];
	int fail_count;
	int stuck_cycles;
	int bytes_taken;
	int chars_seen;
	int lf_seen;
	int messages_done;
	int burst_left;

	// Clock
	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Encode one accepted byte; queue the characters it releases
	task automatic encode_byte(input logic [7:0] data, input logic last,
		input logic [31:0] literal);
		logic [23:0] group;
		logic [5:0] sx;
		int have;
		int n;
		char_beat_t beats [5];
		if (held_count > 2'd2)
			held_count = 2'd2;
		have = int'(held_count) + 1;
		if (have < 3 && !last) begin
			held_bytes[held_count] = data;
			held_count = held_count + 2'd1;
			return;
		end
		if (have == 1)
			group = {data, 16'h0000};
		else if (have == 2)
			group = {held_bytes[0], data, 8'h00};
		else
			group = {held_bytes[0], held_bytes[1], data};
		for (int i = 0; i < 4; i++) begin
			sx = group[23 - 6 * i -: 6];
			beats[i] = '{ch: (i <= have) ? B64_ALPHABET[int'(sx)] : PAD_CHAR,
				run_end: 1'b0, message_end: 1'b0};
			if (literal != 32'd0)
				beats[i].ch = literal[31 - 8 * i -: 8];
		end
		n = 4;
		// close the line after the last group of a full line
		groups_since_lf = groups_since_lf + 5'd1;
		if (groups_since_lf == 5'd0 || groups_since_lf >= LINE_GROUPS) begin
			beats[4] = '{ch: LINE_FEED, run_end: 1'b0, message_end: 1'b0};
			n = 5;
			groups_since_lf = 5'd0;
		end
		beats[n - 1].run_end = 1'b1;
		if (last) begin
			beats[n - 1].message_end = 1'b1;
			groups_since_lf = 5'd0;
			messages_done++;
		end
		for (int i = 0; i < n; i++)
			expected_chars.insert(expected_chars.size(), beats[i]);
		held_bytes[0] = 8'h00;
		held_bytes[1] = 8'h00;
		held_count = 2'd0;
	endtask

	// Offer one byte: possibly idle between bursts, then hold it until it is taken
	task automatic send_byte(input logic [7:0] data, input logic last,
		input logic [31:0] literal);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, 7);
			repeat (gap) begin
				@(negedge clk);
				byte_ch.valid <= 1'b0;
			end
			burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(30, 60)
				: $urandom_range(1, 12);
		end
		@(negedge clk);
		byte_ch.valid <= 1'b1;
		byte_ch.data_byte <= data;
		byte_ch.final_byte <= last;
		literal_chars <= literal;
		@(posedge clk);
		while (!byte_ch.ready)
			@(posedge clk);
		burst_left--;
	endtask

	// Receiver stall pattern: free running, random, stall bursts, periodic
	always @(negedge clk) begin : stall_gen
		static int mode = 0;
		static int mode_left = 0;
		static int stall_left = 0;
		static int phase = 0;
		logic rdy;
		if (mode_left == 0) begin
			mode = $urandom_range(0, 3);
			mode_left = $urandom_range(20, 150);
		end
		mode_left--;
		phase++;
		case (mode)
			0: begin
				rdy = 1'b1;
			end
			1: begin
				rdy = ($urandom_range(0, 2) != 0);
			end
			2: begin
				if (stall_left > 0) begin
					stall_left--;
					rdy = 1'b0;
				end else if ($urandom_range(0, 5) == 0) begin
					stall_left = $urandom_range(1, 8);
					rdy = 1'b0;
				end else begin
					rdy = 1'b1;
				end
			end
			default: begin
				rdy = (phase % 3 != 0);
			end
		endcase
		char_ch.ready <= rdy;
	end

	// Track accepted bytes, check characters, watch for a hang
	always @(posedge clk) begin : scoreboard
		char_beat_t want;
		logic progress;
		if (arst_n) begin
			progress = 1'b0;
			if (byte_ch.valid && byte_ch.ready) begin
				encode_byte(byte_ch.data_byte, byte_ch.final_byte, literal_chars);
				bytes_taken++;
				progress = 1'b1;
			end
			if (char_ch.valid && char_ch.ready) begin
				progress = 1'b1;
				chars_seen++;
				if (char_ch.out_char == LINE_FEED)
					lf_seen++;
				if (expected_chars.size() == 0) begin
					$error("unexpected character 0x%02h", char_ch.out_char);
					fail_count++;
				end else begin
					want = expected_chars.pop_front();
					if (char_ch.out_char !== want.ch) begin
						$error("out_char: expected 0x%02h, got 0x%02h", want.ch,
							char_ch.out_char);
						fail_count++;
					end
					if (char_ch.run_end !== want.run_end) begin
						$error("run_end: expected %0b, got %0b", want.run_end,
							char_ch.run_end);
						fail_count++;
					end
					if (char_ch.message_end !== want.message_end) begin
						$error("message_end: expected %0b, got %0b", want.message_end,
							char_ch.message_end);
						fail_count++;
					end
				end
			end
			stuck_cycles = progress ? 0 : stuck_cycles + 1;
			if (stuck_cycles >= STUCK_LIMIT) begin
				$display("timeout: no beat for %0d cycles", STUCK_LIMIT);
				$display("== FAIL ==");
				$finish;
			end
		end
	end

	// Main sequence
	initial begin : main
		int sent;
		int len;
		arst_n = 1'b0;
		byte_ch.valid = 1'b0;
		byte_ch.data_byte = 8'h00;
		byte_ch.final_byte = 1'b0;
		char_ch.ready = 1'b0;
		literal_chars = 32'd0;
		held_bytes[0] = 8'h00;
		held_bytes[1] = 8'h00;
		held_count = 2'd0;
		groups_since_lf = 5'd0;
		fail_count = 0;
		stuck_cycles = 0;
		bytes_taken = 0;
		chars_seen = 0;
		lf_seen = 0;
		messages_done = 0;
		burst_left = 0;
		repeat (7) @(negedge clk);
		arst_n = 1'b1;

		// walk the directed table
		for (int r = 0; r < NUM_ROWS; r++)
			send_byte(BYTE_ROWS[r].data, BYTE_ROWS[r].last, BYTE_ROWS[r].literal);

		// random messages; the first ends exactly on a full line
		sent = 0;
		len = 3 * LINE_GROUPS;
		while (sent < RANDOM_BYTES) begin
			for (int i = 0; i < len; i++)
				send_byte(8'($urandom_range(0, 255)), (i == len - 1), 32'd0);
			sent += len;
			len = ($urandom_range(0, 3) == 0) ? $urandom_range(3 * LINE_GROUPS - 3,
				3 * LINE_GROUPS + 5) : $urandom_range(1, 8);
		end
		@(negedge clk);
		byte_ch.valid <= 1'b0;

		// drain, then allow stray characters to show up
		while (expected_chars.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);

		$display("Encoded %0d messages: %0d bytes in, %0d characters out, %0d line feeds.",
			messages_done, bytes_taken, chars_seen, lf_seen);
		$display("Mismatches: %0d", fail_count);
		if (fail_count == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule
